[src/lru_page_replacement_assert.svh]
// Assertion macros shared by the LRU page replacement RTL.
// Included by files that check their own logic; the SYNTH build maps them to nothing.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTH
`define LRU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lru assertion failed");
`define LRU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lru assertion failed");
`else
`define LRU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LRU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[src/lru_pkg.sv]
// Shared constants, types and helpers for the LRU page replacement block.
// No dependencies; used by every module of the block.
`default_nettype none

package lru_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W       = 4;
    localparam int FRAME_IDX_W = 3;
    localparam int FAULT_W     = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;
    localparam int REG_IDX_W   = 1;

    localparam logic [CFG_W-1:0]     FIU_RESET         = 4'd8;
    localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic found;
        logic have_empty;
        logic have_victim;
    } scan_flags_t;

    // Clamp the frames_in_use register to 1..frames.
    function automatic int active_count(logic [CFG_W-1:0] fiu, int frames);
        int n;
        n = int'(fiu);
        if (n == 0) begin
            n = 1;
        end
        if (n > frames) begin
            n = frames;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

[src/lru_page_store.sv]
// Page number store: one write port, one registered read port.
// Depends on lru_pkg for nothing but defaults; contents undefined until written.
`default_nettype none

module lru_page_store #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] waddr,
    input  wire logic [PAGE_BITS-1:0]   wdata,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] raddr,
    output logic      [PAGE_BITS-1:0]   rdata
);

    logic [PAGE_BITS-1:0] mem [FRAMES];
    logic [PAGE_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/lru_scan_unit.sv]
// Shared compare unit: looks at one frame per cycle while en is high and keeps the first hit,
// the first empty frame and the oldest valid frame. Depends on lru_pkg.
`default_nettype none

module lru_scan_unit #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   clear,
    input  wire logic                   en,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] idx,
    input  wire logic [PAGE_BITS-1:0]   key,
    input  wire logic [PAGE_BITS-1:0]   page_data,
    input  wire logic                   frame_valid,
    input  wire logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] frame_rank,
    output lru_pkg::scan_flags_t        flags,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hit_idx,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] hit_rank,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] empty_idx,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] victim_idx,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] victim_rank,
    output logic [PAGE_BITS-1:0]        victim_page
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    lru_pkg::scan_flags_t flags_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     victim_idx_reg;
    logic [IDX_W-1:0]     victim_rank_reg;
    logic [PAGE_BITS-1:0] victim_page_reg;

    logic take_hit;
    logic take_empty;
    logic take_victim;

    always_comb begin
        take_hit    = en && frame_valid && (page_data == key) && !flags_reg.found;
        take_empty  = en && !frame_valid && !flags_reg.have_empty;
        // strict compare keeps the lowest index among equal oldest ranks
        take_victim = en && frame_valid &&
                      (!flags_reg.have_victim || (frame_rank > victim_rank_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (clear) begin
            flags_reg <= '0;
        end else begin
            if (take_hit) begin
                flags_reg.found <= 1'b1;
            end
            if (take_empty) begin
                flags_reg.have_empty <= 1'b1;
            end
            if (take_victim) begin
                flags_reg.have_victim <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_hit) begin
            hit_idx_reg  <= idx;
            hit_rank_reg <= frame_rank;
        end
        if (take_empty) begin
            empty_idx_reg <= idx;
        end
        if (take_victim) begin
            victim_idx_reg  <= idx;
            victim_rank_reg <= frame_rank;
            victim_page_reg <= page_data;
        end
    end

    assign flags       = flags_reg;
    assign hit_idx     = hit_idx_reg;
    assign hit_rank    = hit_rank_reg;
    assign empty_idx   = empty_idx_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_rank = victim_rank_reg;
    assign victim_page = victim_page_reg;

endmodule

`default_nettype wire

[src/lru_page_replacement.sv]
// LRU page replacement, fully associative. A new reference is accepted only in idle,
// after the last one's result has been loaded into the result register, and that load
// waits while the result register still holds a result that m_ready has not taken. The scan reads
// the page store one frame per cycle through its single read port into the shared
// compare unit. Reset (aresetn low, synchronous): all frames empty, ranks and fault
// count zero, frames_in_use 8; page store untouched.
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lru_page_replacement #(
    parameter int FRAMES    = lru_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lru_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [lru_pkg::DATA_W-1:0]    pwdata,
    output logic      [lru_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [PAGE_BITS-1:0]          s_page,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic [lru_pkg::FRAME_IDX_W-1:0]    m_frame_index,
    output logic                               m_evicted_valid,
    output logic [PAGE_BITS-1:0]               m_evicted_page,
    output logic [lru_pkg::FAULT_W-1:0]        m_fault_total
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] RANK_MAX   = RANK_W'(FRAMES - 1);
    localparam logic [CNT_W-1:0]  LIMIT_FILL = CNT_W'(FRAMES);

    lru_pkg::state_t state_reg, state_next;

    logic [lru_pkg::CFG_W-1:0]   fiu_reg;
    logic [FRAMES-1:0]           valid_reg;
    logic [RANK_W-1:0]           rank_reg [FRAMES];
    logic [lru_pkg::FAULT_W-1:0] fault_reg;
    logic [PAGE_BITS-1:0]        key_reg;
    logic [CNT_W-1:0]            rd_cnt_reg;
    logic                        cmp_en_reg;
    logic [IDX_W-1:0]            cmp_idx_reg;

    logic                             m_valid_reg;
    logic                             m_hit_reg;
    logic [lru_pkg::FRAME_IDX_W-1:0]  m_frame_index_reg;
    logic                             m_evicted_valid_reg;
    logic [PAGE_BITS-1:0]             m_evicted_page_reg;
    logic [lru_pkg::FAULT_W-1:0]      m_fault_total_reg;

    logic scan_clear;
    logic rd_issue;
    logic out_load;

    logic [CNT_W-1:0] n_act;
    logic [CNT_W-1:0] n_cfg;
    logic             cfg_wr;
    logic             cfg_sel;

    lru_pkg::scan_flags_t flags;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     hit_rank;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     victim_idx;
    logic [IDX_W-1:0]     victim_rank;
    logic [PAGE_BITS-1:0] victim_page;
    logic [PAGE_BITS-1:0] rd_page;

    logic [IDX_W-1:0]            f_sel;
    logic [CNT_W-1:0]            limit;
    logic                        evict;
    logic [31:0]                 f_ext;
    logic [RANK_W-1:0]           rank_upd [FRAMES];
    logic [FRAMES-1:0]           valid_upd;
    logic [lru_pkg::FAULT_W-1:0] fault_next;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[lru_pkg::ADDR_W-1:2] == lru_pkg::REG_FRAMES_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign n_act   = CNT_W'(lru_pkg::active_count(fiu_reg, FRAMES));
    assign n_cfg   = CNT_W'(lru_pkg::active_count(pwdata[lru_pkg::CFG_W-1:0], FRAMES));

    always_comb begin
        prdata = '0;
        if (cfg_sel) begin
            prdata = lru_pkg::DATA_W'(fiu_reg);
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lru_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        scan_clear = 1'b0;
        rd_issue   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            lru_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    scan_clear = 1'b1;
                    state_next = lru_pkg::ST_SCAN;
                end
            end
            lru_pkg::ST_SCAN: begin
                rd_issue = (rd_cnt_reg < n_act);
                // drain the compare stage before deciding
                if (!rd_issue && !cmp_en_reg) begin
                    state_next = lru_pkg::ST_UPDATE;
                end
            end
            lru_pkg::ST_UPDATE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = lru_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lru_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan pointer and compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            if (scan_clear) begin
                rd_cnt_reg <= '0;
            end else if (rd_issue) begin
                rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
            end
            cmp_en_reg <= rd_issue;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= rd_cnt_reg[IDX_W-1:0];
        if (scan_clear) begin
            key_reg <= s_page;
        end
    end

    lru_page_store #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_store (
        .aclk  (aclk),
        .we    (out_load && !flags.found),
        .waddr (f_sel),
        .wdata (key_reg),
        .raddr (rd_cnt_reg[IDX_W-1:0]),
        .rdata (rd_page)
    );

    lru_scan_unit #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (scan_clear),
        .en          (cmp_en_reg),
        .idx         (cmp_idx_reg),
        .key         (key_reg),
        .page_data   (rd_page),
        .frame_valid (valid_reg[cmp_idx_reg]),
        .frame_rank  (rank_reg[cmp_idx_reg]),
        .flags       (flags),
        .hit_idx     (hit_idx),
        .hit_rank    (hit_rank),
        .empty_idx   (empty_idx),
        .victim_idx  (victim_idx),
        .victim_rank (victim_rank),
        .victim_page (victim_page)
    );

    // Placement decision and recency update
    always_comb begin
        evict = !flags.found && !flags.have_empty;
        if (flags.found) begin
            f_sel = hit_idx;
            limit = CNT_W'(hit_rank);
        end else if (flags.have_empty) begin
            f_sel = empty_idx;
            limit = LIMIT_FILL;
        end else begin
            f_sel = victim_idx;
            limit = CNT_W'(victim_rank);
        end
        f_ext = 32'(f_sel);

        for (int j = 0; j < FRAMES; j++) begin
            rank_upd[j]  = rank_reg[j];
            valid_upd[j] = valid_reg[j];
            if ((j < int'(n_act)) && (IDX_W'(j) != f_sel) && valid_reg[j] &&
                (CNT_W'(rank_reg[j]) < limit) && (rank_reg[j] < RANK_MAX)) begin
                rank_upd[j] = rank_reg[j] + RANK_W'(1);
            end
            if (IDX_W'(j) == f_sel) begin
                rank_upd[j]  = '0;
                valid_upd[j] = 1'b1;
            end
        end

        fault_next = fault_reg;
        if (!flags.found && (fault_reg != '1)) begin
            fault_next = fault_reg + lru_pkg::FAULT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fiu_reg   <= lru_pkg::FIU_RESET;
            valid_reg <= '0;
            fault_reg <= '0;
            for (int j = 0; j < FRAMES; j++) begin
                rank_reg[j] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                fiu_reg <= pwdata[lru_pkg::CFG_W-1:0];
                // drop frames above the new active count
                for (int j = 0; j < FRAMES; j++) begin
                    if (j >= int'(n_cfg)) begin
                        valid_reg[j] <= 1'b0;
                        rank_reg[j]  <= '0;
                    end
                end
            end
            if (out_load) begin
                valid_reg <= valid_upd;
                fault_reg <= fault_next;
                for (int j = 0; j < FRAMES; j++) begin
                    rank_reg[j] <= rank_upd[j];
                end
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_reg           <= flags.found;
            m_frame_index_reg   <= f_ext[lru_pkg::FRAME_IDX_W-1:0];
            m_evicted_valid_reg <= evict;
            m_evicted_page_reg  <= evict ? victim_page : '0;
            m_fault_total_reg   <= fault_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_frame_index   = m_frame_index_reg;
    assign m_evicted_valid = m_evicted_valid_reg;
    assign m_evicted_page  = m_evicted_page_reg;
    assign m_fault_total   = m_fault_total_reg;

    `LRU_ASSERT_NEXT(a_accept_starts_scan, aclk, aresetn, s_valid && s_ready, state_reg == lru_pkg::ST_SCAN)
    `LRU_ASSERT_IMPL(a_update_after_drain, aclk, aresetn, state_reg == lru_pkg::ST_UPDATE, !cmp_en_reg)
    `LRU_ASSERT_NEXT(a_fault_monotonic, aclk, aresetn, out_load, fault_reg >= $past(fault_reg))
    `LRU_ASSERT_IMPL(a_result_from_update, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == lru_pkg::ST_UPDATE)
    `LRU_ASSERT_IMPL(a_evict_only_on_fault, aclk, aresetn, m_valid_reg, !(m_hit_reg && m_evicted_valid_reg))

endmodule

`default_nettype wire
